// ===== hw/rtl/jtl_pkg.sv =====
// Shared types, character codes and result codes for the JSON token lexer.
`timescale 1ns / 1ps

package jtl_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_STRING  = 2'd1,
		MODE_NUMBER  = 2'd2,
		MODE_KEYWORD = 2'd3
	} mode_t;

	localparam logic [1:0] EV_CONTENT = 2'd0;
	localparam logic [1:0] EV_TOKEN   = 2'd1;
	localparam logic [1:0] EV_ERROR   = 2'd2;

	localparam logic [3:0] TK_NONE    = 4'd0;
	localparam logic [3:0] TK_LBRACE  = 4'd0;
	localparam logic [3:0] TK_RBRACE  = 4'd1;
	localparam logic [3:0] TK_LSQUARE = 4'd2;
	localparam logic [3:0] TK_RSQUARE = 4'd3;
	localparam logic [3:0] TK_COLON   = 4'd4;
	localparam logic [3:0] TK_COMMA   = 4'd5;
	localparam logic [3:0] TK_STRING  = 4'd6;
	localparam logic [3:0] TK_INT     = 4'd7;
	localparam logic [3:0] TK_FLOAT   = 4'd8;
	localparam logic [3:0] TK_BOOL    = 4'd9;

	localparam logic [2:0] ER_NONE        = 3'd0;
	localparam logic [2:0] ER_OPEN_STRING = 3'd0;
	localparam logic [2:0] ER_OPEN_NUMBER = 3'd1;
	localparam logic [2:0] ER_TWO_POINTS  = 3'd2;
	localparam logic [2:0] ER_BAD_KEYWORD = 3'd3;
	localparam logic [2:0] ER_UNEXPECTED  = 3'd4;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_POINT   = 8'h2E;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CH_F       = 8'h66;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_COMMA   = 8'h2C;

	typedef struct packed {
		mode_t      mode;
		logic [2:0] kw_progress;
		logic       kw_is_false;
		logic       point_seen;
		logic       halted;
	} lex_state_t;

	localparam lex_state_t STATE_RESET = '{
		mode: MODE_IDLE, kw_progress: 3'd0, kw_is_false: 1'b0,
		point_seen: 1'b0, halted: 1'b0
	};

	typedef struct packed {
		logic [1:0] event_kind;
		logic [3:0] token_kind;
		logic [7:0] content_byte;
		logic       bool_value;
		logic [2:0] error_code;
		logic       last_result;
	} result_t;

	// up to two results per input byte
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} step_out_t;

	function automatic result_t make_result(input logic [1:0] ev, input logic [3:0] tok,
		input logic [7:0] b, input logic bval, input logic [2:0] err);
		result_t r;
		r.event_kind   = ev;
		r.token_kind   = tok;
		r.content_byte = b;
		r.bool_value   = bval;
		r.error_code   = err;
		r.last_result  = 1'b0;
		return r;
	endfunction

	// keyword letters: "true" and "false", position 0..4
	function automatic logic [7:0] kw_char(input logic is_false, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		if (is_false) begin
			unique case (pos)
				3'd0: ch = 8'h66;
				3'd1: ch = 8'h61;
				3'd2: ch = 8'h6C;
				3'd3: ch = 8'h73;
				3'd4: ch = 8'h65;
				default: ch = 8'h00;
			endcase
		end else begin
			unique case (pos)
				3'd0: ch = 8'h74;
				3'd1: ch = 8'h72;
				3'd2: ch = 8'h75;
				3'd3: ch = 8'h65;
				default: ch = 8'h00;
			endcase
		end
		return ch;
	endfunction

endpackage

// ===== hw/rtl/jtl_step.sv =====
// Next-state and result logic of the lexer for one input byte.
`timescale 1ns / 1ps

module jtl_step (
	input  jtl_pkg::lex_state_t state,
	input  logic [7:0]          char_byte,
	input  logic                end_of_input,
	output jtl_pkg::lex_state_t state_next,
	output jtl_pkg::step_out_t  step
);
	import jtl_pkg::*;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
		lex_state_t st;
	} idle_out_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// byte seen in idle mode; errors also halt
	function automatic idle_out_t idle_byte(input logic [7:0] c, input logic eoi,
		input lex_state_t st_in);
		idle_out_t o;
		o.count = 2'd0;
		o.r0    = '0;
		o.r1    = '0;
		o.st    = st_in;
		o.st.mode = MODE_IDLE;
		priority if (c == CH_TAB || c == CH_NEWLINE || c == CH_SPACE) begin
			o.count = 2'd0;
		end else if (c == CH_QUOTE) begin
			o.st.mode = MODE_STRING;
			if (eoi) begin
				o.count = 2'd1;
				o.r0 = make_result(EV_ERROR, TK_NONE, 8'h00, 1'b0, ER_OPEN_STRING);
				o.st.halted = 1'b1;
				o.st.mode = MODE_IDLE;
			end
		end else if (c == CH_T || c == CH_F) begin
			o.st.mode = MODE_KEYWORD;
			o.st.kw_is_false = (c == CH_F);
			o.st.kw_progress = 3'd1;
			if (eoi) begin
				o.count = 2'd1;
				o.r0 = make_result(EV_ERROR, TK_NONE, 8'h00, 1'b0, ER_BAD_KEYWORD);
				o.st.halted = 1'b1;
				o.st.mode = MODE_IDLE;
			end
		end else if (c == CH_LBRACE) begin
			o.count = 2'd1;
			o.r0 = make_result(EV_TOKEN, TK_LBRACE, 8'h00, 1'b0, ER_NONE);
		end else if (c == CH_RBRACE) begin
			o.count = 2'd1;
			o.r0 = make_result(EV_TOKEN, TK_RBRACE, 8'h00, 1'b0, ER_NONE);
		end else if (c == CH_LSQUARE) begin
			o.count = 2'd1;
			o.r0 = make_result(EV_TOKEN, TK_LSQUARE, 8'h00, 1'b0, ER_NONE);
		end else if (c == CH_RSQUARE) begin
			o.count = 2'd1;
			o.r0 = make_result(EV_TOKEN, TK_RSQUARE, 8'h00, 1'b0, ER_NONE);
		end else if (c == CH_COLON) begin
			o.count = 2'd1;
			o.r0 = make_result(EV_TOKEN, TK_COLON, 8'h00, 1'b0, ER_NONE);
		end else if (c == CH_COMMA) begin
			o.count = 2'd1;
			o.r0 = make_result(EV_TOKEN, TK_COMMA, 8'h00, 1'b0, ER_NONE);
		end else if (c == CH_MINUS || is_digit(c)) begin
			o.st.mode = MODE_NUMBER;
			o.st.point_seen = 1'b0;
			o.count = 2'd1;
			o.r0 = make_result(EV_CONTENT, TK_NONE, c, 1'b0, ER_NONE);
			if (eoi) begin
				o.count = 2'd2;
				o.r1 = make_result(EV_ERROR, TK_NONE, 8'h00, 1'b0, ER_OPEN_NUMBER);
				o.st.halted = 1'b1;
				o.st.mode = MODE_IDLE;
			end
		end else begin
			o.count = 2'd1;
			o.r0 = make_result(EV_ERROR, TK_NONE, 8'h00, 1'b0, ER_UNEXPECTED);
			o.st.halted = 1'b1;
		end
		return o;
	endfunction

	idle_out_t  idle;
	lex_state_t st;
	step_out_t  so;
	logic       is_point;
	logic [2:0] kw_len;
	logic [2:0] kw_next;

	always_comb begin
		idle     = '0;
		st       = state;
		so       = '0;
		is_point = (char_byte == CH_POINT);
		kw_len   = state.kw_is_false ? 3'd5 : 3'd4;
		kw_next  = state.kw_progress + 3'd1;

		if (state.halted) begin
			so.count = 2'd0;
		end else begin
			unique case (state.mode)
				MODE_STRING: begin
					if (char_byte == CH_QUOTE) begin
						st.mode = MODE_IDLE;
						so.count = 2'd1;
						so.r0 = make_result(EV_TOKEN, TK_STRING, 8'h00, 1'b0, ER_NONE);
					end else begin
						so.count = 2'd1;
						so.r0 = make_result(EV_CONTENT, TK_NONE, char_byte, 1'b0, ER_NONE);
						if (end_of_input) begin
							so.count = 2'd2;
							so.r1 = make_result(EV_ERROR, TK_NONE, 8'h00, 1'b0,
								ER_OPEN_STRING);
							st.halted = 1'b1;
							st.mode = MODE_IDLE;
						end
					end
				end
				MODE_NUMBER: begin
					if (is_digit(char_byte) || is_point) begin
						if (is_point && state.point_seen) begin
							so.count = 2'd1;
							so.r0 = make_result(EV_ERROR, TK_NONE, 8'h00, 1'b0,
								ER_TWO_POINTS);
							st.halted = 1'b1;
							st.mode = MODE_IDLE;
						end else begin
							st.point_seen = state.point_seen | is_point;
							so.count = 2'd1;
							so.r0 = make_result(EV_CONTENT, TK_NONE, char_byte, 1'b0,
								ER_NONE);
							if (end_of_input) begin
								so.count = 2'd2;
								so.r1 = make_result(EV_ERROR, TK_NONE, 8'h00, 1'b0,
									ER_OPEN_NUMBER);
								st.halted = 1'b1;
								st.mode = MODE_IDLE;
							end
						end
					end else begin
						// number ends; terminator replays in idle, only its last result kept
						so.count = 2'd1;
						so.r0 = make_result(EV_TOKEN,
							state.point_seen ? TK_FLOAT : TK_INT, 8'h00, 1'b0, ER_NONE);
						st.mode = MODE_IDLE;
						st.point_seen = 1'b0;
						idle = idle_byte(char_byte, end_of_input, st);
						st = idle.st;
						if (idle.count != 2'd0) begin
							so.count = 2'd2;
							so.r1 = (idle.count == 2'd2) ? idle.r1 : idle.r0;
						end
					end
				end
				MODE_KEYWORD: begin
					if (state.kw_progress >= kw_len ||
						char_byte != kw_char(state.kw_is_false, state.kw_progress)) begin
						so.count = 2'd1;
						so.r0 = make_result(EV_ERROR, TK_NONE, 8'h00, 1'b0, ER_BAD_KEYWORD);
						st.halted = 1'b1;
						st.mode = MODE_IDLE;
					end else begin
						st.kw_progress = kw_next;
						if (kw_next == kw_len) begin
							st.mode = MODE_IDLE;
							st.kw_progress = 3'd0;
							so.count = 2'd1;
							so.r0 = make_result(EV_TOKEN, TK_BOOL, 8'h00,
								~state.kw_is_false, ER_NONE);
						end else if (end_of_input) begin
							so.count = 2'd1;
							so.r0 = make_result(EV_ERROR, TK_NONE, 8'h00, 1'b0,
								ER_BAD_KEYWORD);
							st.halted = 1'b1;
							st.mode = MODE_IDLE;
						end
					end
				end
				MODE_IDLE: begin
					idle = idle_byte(char_byte, end_of_input, state);
					st = idle.st;
					so.count = idle.count;
					so.r0 = idle.r0;
					so.r1 = idle.r1;
				end
			endcase
		end

		if (end_of_input) begin
			st = STATE_RESET;
		end
		if (so.count == 2'd1) begin
			so.r0.last_result = 1'b1;
		end
		if (so.count == 2'd2) begin
			so.r1.last_result = 1'b1;
		end
	end

	assign state_next = st;
	assign step       = so;

endmodule

// ===== hw/rtl/json_token_lexer_core.sv =====
// Streaming JSON lexer: one byte in per beat, literal bytes, tokens and errors out.
// Each accepted byte is registered, lexed into the result queue when it has room, and presented from the queue head.
// Throughput: one byte per cycle; a byte with two results needs two output beats,
// and a 4-entry result queue absorbs them; input stalls while fewer than two are free.
// Reset: arst_n clears the lexer state, input valid flag, queue pointers and queue count at once.
`timescale 1ns / 1ps

module json_token_lexer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [3:0] token_kind, [11:4] content_byte,
	                               // [12] bool_value, [15:13] error_code
	output logic [1:0]  m_tuser,   // [1:0] event_kind
	output logic        m_tlast    // last_result
);
	import jtl_pkg::*;

	localparam int Depth = 4;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	logic            v_s1;
	logic [7:0]      byte_s1;
	logic            eoi_s1;
	lex_state_t      state_q;
	lex_state_t      state_next;
	step_out_t       step;
	result_t         fifo_q [Depth];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [CntW-1:0] count_q;
	logic            can_process;
	logic            proc;
	logic            pop;
	result_t         head;

	jtl_step u_step (
		.state        (state_q),
		.char_byte    (byte_s1),
		.end_of_input (eoi_s1),
		.state_next   (state_next),
		.step         (step)
	);

	// room for the worst case of two results per byte
	assign can_process = (count_q <= CntW'(Depth - 2));
	assign proc        = v_s1 && can_process;
	assign s_tready    = !v_s1 || can_process;
	assign pop         = m_tvalid && m_tready;
	assign head        = fifo_q[rptr_q];

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {head.error_code, head.bool_value, head.content_byte, head.token_kind};
	assign m_tuser  = head.event_kind;
	assign m_tlast  = head.last_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			state_q <= STATE_RESET;
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				v_s1 <= 1'b1;
			end else if (proc) begin
				v_s1 <= 1'b0;
			end
			if (proc) begin
				state_q <= state_next;
				wptr_q  <= wptr_q + PtrW'(step.count);
			end
			if (pop) begin
				rptr_q <= rptr_q + PtrW'(1);
			end
			count_q <= count_q + (proc ? CntW'(step.count) : CntW'(0)) - CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
		if (proc && step.count != 2'd0) begin
			fifo_q[wptr_q] <= step.r0;
		end
		if (proc && step.count == 2'd2) begin
			fifo_q[wptr_q + PtrW'(1)] <= step.r1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("result queue overflow");

	a_hold_stalled_byte: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !can_process |=> v_s1 && $stable(byte_s1) && $stable(eoi_s1))
		else $error("stalled input byte lost");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		proc && state_q.halted |-> step.count == 2'd0)
		else $error("result produced while halted on error");

	a_eoi_resets: assert property (@(posedge clk) disable iff (!arst_n)
		proc && eoi_s1 |=> state_q == STATE_RESET)
		else $error("state not cleared after end of input");

endmodule

// ===== dv/testbench.sv =====
// Self-checking stream testbench for json_token_lexer_core: table-driven and random JSON bytes.
`timescale 1ns / 1ps

module testbench;
	import jtl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 175;
	localparam int DRAIN_CYCLES = 16;
	localparam int SEND_IDLE_PCT [4] = '{0, 45, 0, 8};
	localparam int RECV_STALL_PCT [4] = '{0, 0, 45, 8};
	localparam logic [7:0] PUNCT [6] = '{CH_LBRACE, CH_RBRACE, CH_LSQUARE, CH_RSQUARE,
		CH_COLON, CH_COMMA};
	localparam logic [7:0] SPACING [3] = '{CH_TAB, CH_NEWLINE, CH_SPACE};

	typedef struct {
		logic [7:0] ch;
		bit         eoi;
		bit         typed;
		int         n;
		result_t    r0;
		result_t    r1;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// lexer state mirror
	mode_t      lex_mode = MODE_IDLE;
	logic [2:0] kw_pos = 3'd0;
	logic       kw_false = 1'b0;
	logic       point_seen = 1'b0;
	logic       lex_halted = 1'b0;

	result_t    lex_expected[$];
	result_t    step_res[$];
	result_t    idle_res[$];
	stim_row_t  dir_rows[$];
	logic [7:0] doc_bytes[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int beat_count = 0;
	int cycle_count = 0;
	int counted_items = 0;

	json_token_lexer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats pending", cycle_count,
				lex_expected.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic result_t lex_beat(input logic [1:0] ev, input logic [3:0] tok,
		input logic [7:0] b, input logic bval, input logic [2:0] err);
		result_t r;
		r.event_kind   = ev;
		r.token_kind   = tok;
		r.content_byte = b;
		r.bool_value   = bval;
		r.error_code   = err;
		r.last_result  = 1'b0;
		return r;
	endfunction

	function automatic void clear_state();
		lex_mode   = MODE_IDLE;
		kw_pos     = 3'd0;
		kw_false   = 1'b0;
		point_seen = 1'b0;
		lex_halted = 1'b0;
	endfunction

	function automatic result_t halt_on(input logic [2:0] code);
		lex_halted = 1'b1;
		lex_mode   = MODE_IDLE;
		return lex_beat(EV_ERROR, TK_NONE, 8'h00, 1'b0, code);
	endfunction

	function automatic bit is_decimal(input logic [7:0] ch);
		return ch >= CH_ZERO && ch <= CH_NINE;
	endfunction

	// byte seen in idle mode; results go to idle_res
	function automatic void idle_byte(input logic [7:0] ch, input bit eoi);
		idle_res.delete();
		case (ch)
		CH_TAB, CH_NEWLINE, CH_SPACE: ;
		CH_QUOTE: begin
			lex_mode = MODE_STRING;
			if (eoi) idle_res.insert(idle_res.size(), halt_on(ER_OPEN_STRING));
		end
		CH_T, CH_F: begin
			lex_mode = MODE_KEYWORD;
			kw_false = (ch == CH_F);
			kw_pos   = 3'd1;
			if (eoi) idle_res.insert(idle_res.size(), halt_on(ER_BAD_KEYWORD));
		end
		CH_LBRACE:  idle_res.insert(idle_res.size(),
			lex_beat(EV_TOKEN, TK_LBRACE, 8'h00, 1'b0, ER_NONE));
		CH_RBRACE:  idle_res.insert(idle_res.size(),
			lex_beat(EV_TOKEN, TK_RBRACE, 8'h00, 1'b0, ER_NONE));
		CH_LSQUARE: idle_res.insert(idle_res.size(),
			lex_beat(EV_TOKEN, TK_LSQUARE, 8'h00, 1'b0, ER_NONE));
		CH_RSQUARE: idle_res.insert(idle_res.size(),
			lex_beat(EV_TOKEN, TK_RSQUARE, 8'h00, 1'b0, ER_NONE));
		CH_COLON:   idle_res.insert(idle_res.size(),
			lex_beat(EV_TOKEN, TK_COLON, 8'h00, 1'b0, ER_NONE));
		CH_COMMA:   idle_res.insert(idle_res.size(),
			lex_beat(EV_TOKEN, TK_COMMA, 8'h00, 1'b0, ER_NONE));
		default: begin
			if (ch == CH_MINUS || is_decimal(ch)) begin
				lex_mode   = MODE_NUMBER;
				point_seen = 1'b0;
				idle_res.insert(idle_res.size(),
					lex_beat(EV_CONTENT, TK_NONE, ch, 1'b0, ER_NONE));
				if (eoi) idle_res.insert(idle_res.size(), halt_on(ER_OPEN_NUMBER));
			end else begin
				idle_res.insert(idle_res.size(), halt_on(ER_UNEXPECTED));
			end
		end
		endcase
	endfunction

	// advance the lexer mirror by one byte; results land in step_res
	function automatic void predict_byte(input logic [7:0] ch, input bit eoi);
		string kw_word;
		step_res.delete();
		if (lex_halted) begin
			if (eoi) clear_state();
			return;
		end
		case (lex_mode)
		MODE_STRING: begin
			if (ch == CH_QUOTE) begin
				lex_mode = MODE_IDLE;
				step_res.insert(step_res.size(),
					lex_beat(EV_TOKEN, TK_STRING, 8'h00, 1'b0, ER_NONE));
			end else begin
				step_res.insert(step_res.size(),
					lex_beat(EV_CONTENT, TK_NONE, ch, 1'b0, ER_NONE));
				if (eoi) step_res.insert(step_res.size(), halt_on(ER_OPEN_STRING));
			end
		end
		MODE_NUMBER: begin
			if (is_decimal(ch) || ch == CH_POINT) begin
				if (ch == CH_POINT && point_seen) begin
					step_res.insert(step_res.size(), halt_on(ER_TWO_POINTS));
				end else begin
					if (ch == CH_POINT) point_seen = 1'b1;
					step_res.insert(step_res.size(),
						lex_beat(EV_CONTENT, TK_NONE, ch, 1'b0, ER_NONE));
					if (eoi) step_res.insert(step_res.size(), halt_on(ER_OPEN_NUMBER));
				end
			end else begin
				step_res.insert(step_res.size(), lex_beat(EV_TOKEN,
					point_seen ? TK_FLOAT : TK_INT, 8'h00, 1'b0, ER_NONE));
				lex_mode   = MODE_IDLE;
				point_seen = 1'b0;
				// terminator is re-lexed; only its final beat survives
				idle_byte(ch, eoi);
				if (idle_res.size() != 0)
					step_res.insert(step_res.size(), idle_res[idle_res.size() - 1]);
			end
		end
		MODE_KEYWORD: begin
			if (kw_false) kw_word = "false";
			else kw_word = "true";
			if (kw_pos >= kw_word.len() || ch != kw_word[kw_pos]) begin
				step_res.insert(step_res.size(), halt_on(ER_BAD_KEYWORD));
			end else begin
				kw_pos = kw_pos + 3'd1;
				if (kw_pos == kw_word.len()) begin
					lex_mode = MODE_IDLE;
					kw_pos   = 3'd0;
					step_res.insert(step_res.size(),
						lex_beat(EV_TOKEN, TK_BOOL, 8'h00, !kw_false, ER_NONE));
				end else if (eoi) begin
					step_res.insert(step_res.size(), halt_on(ER_BAD_KEYWORD));
				end
			end
		end
		default: begin
			lex_mode = MODE_IDLE;
			idle_byte(ch, eoi);
			foreach (idle_res[i]) step_res.insert(step_res.size(), idle_res[i]);
		end
		endcase
		if (eoi) clear_state();
		if (step_res.size() != 0) step_res[step_res.size() - 1].last_result = 1'b1;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		if (mismatch_count < 200)
			$display("mismatch at beat %0d: %s got %0d, want %0d", beat_count, field, got, want);
		mismatch_count++;
	endtask

	task automatic check_beat();
		result_t want;
		if (lex_expected.size() == 0) begin
			report_mismatch("unexpected beat, tdata", int'(m_tdata), 0);
		end else begin
			want = lex_expected.pop_front();
			if (m_tuser != want.event_kind)
				report_mismatch("event_kind", int'(m_tuser), int'(want.event_kind));
			if (m_tdata[3:0] != want.token_kind)
				report_mismatch("token_kind", int'(m_tdata[3:0]), int'(want.token_kind));
			if (m_tdata[11:4] != want.content_byte)
				report_mismatch("content_byte", int'(m_tdata[11:4]),
					int'(want.content_byte));
			if (m_tdata[12] != want.bool_value)
				report_mismatch("bool_value", int'(m_tdata[12]), int'(want.bool_value));
			if (m_tdata[15:13] != want.error_code)
				report_mismatch("error_code", int'(m_tdata[15:13]), int'(want.error_code));
			if (m_tlast != want.last_result)
				report_mismatch("last_result", int'(m_tlast), int'(want.last_result));
		end
		beat_count++;
	endtask

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) check_beat();

	// valid stays high across back-to-back beats; a gap lowers it before the next byte is driven
	task automatic send_byte(input logic [7:0] ch, input bit eoi);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= eoi;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic feed_byte(input logic [7:0] ch, input bit eoi);
		send_byte(ch, eoi);
		counted_items++;
		predict_byte(ch, eoi);
		foreach (step_res[i]) lex_expected.insert(lex_expected.size(), step_res[i]);
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (lex_expected.size() != 0);
	endtask

	task automatic add_row(input logic [7:0] ch, input bit eoi, input bit typed, input int n,
		input result_t r0, input result_t r1);
		stim_row_t row;
		row.ch = ch;
		row.eoi = eoi;
		row.typed = typed;
		row.n = n;
		row.r0 = r0;
		row.r1 = r1;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	function automatic void add_lexeme();
		int sel;
		logic [7:0] b;
		string kw_word;
		sel = $urandom_range(99);
		if (sel < 25) begin
			doc_bytes.insert(doc_bytes.size(), PUNCT[$urandom_range(5)]);
		end else if (sel < 45) begin
			doc_bytes.insert(doc_bytes.size(), CH_QUOTE);
			repeat ($urandom_range(5)) begin
				b = 8'($urandom_range(255));
				if (b == CH_QUOTE) b = ~b;
				doc_bytes.insert(doc_bytes.size(), b);
			end
			doc_bytes.insert(doc_bytes.size(), CH_QUOTE);
		end else if (sel < 70) begin
			if ($urandom_range(3) == 0) doc_bytes.insert(doc_bytes.size(), CH_MINUS);
			repeat ($urandom_range(1, 4))
				doc_bytes.insert(doc_bytes.size(), 8'(CH_ZERO + $urandom_range(9)));
			if ($urandom_range(2) == 0) begin
				doc_bytes.insert(doc_bytes.size(), CH_POINT);
				repeat ($urandom_range(3))
					doc_bytes.insert(doc_bytes.size(), 8'(CH_ZERO + $urandom_range(9)));
			end
		end else if (sel < 82) begin
			if ($urandom_range(1) != 0) kw_word = "false";
			else kw_word = "true";
			for (int i = 0; i < kw_word.len(); i++)
				doc_bytes.insert(doc_bytes.size(), kw_word[i]);
		end else if (sel < 92) begin
			doc_bytes.insert(doc_bytes.size(), SPACING[$urandom_range(2)]);
		end else begin
			doc_bytes.insert(doc_bytes.size(), 8'($urandom_range(255)));
		end
		if ($urandom_range(99) < 40) doc_bytes.insert(doc_bytes.size(), SPACING[$urandom_range(2)]);
	endfunction

	// mostly well-formed token runs; about one in five gets cut, mutated or padded
	function automatic void build_document();
		int pos;
		doc_bytes.delete();
		repeat ($urandom_range(1, 8)) add_lexeme();
		if ($urandom_range(99) < 20) begin
			pos = $urandom_range(doc_bytes.size() - 1);
			case ($urandom_range(3))
			0: while (doc_bytes.size() > pos + 1) void'(doc_bytes.pop_back());
			1: doc_bytes[pos] = 8'($urandom_range(255));
			2: doc_bytes.insert(pos, 8'($urandom_range(255)));
			default: doc_bytes.insert(pos, CH_POINT);
			endcase
		end
	endfunction

	initial begin
		result_t nil;
		result_t typed_q[$];
		nil = '0;

		add_row(CH_LBRACE, 0, 1, 1, lex_beat(EV_TOKEN, TK_LBRACE, 8'h00, 0, ER_NONE), nil);
		add_row(CH_RBRACE, 0, 1, 1, lex_beat(EV_TOKEN, TK_RBRACE, 8'h00, 0, ER_NONE), nil);
		add_row(CH_LSQUARE, 0, 1, 1, lex_beat(EV_TOKEN, TK_LSQUARE, 8'h00, 0, ER_NONE), nil);
		add_row(CH_RSQUARE, 0, 1, 1, lex_beat(EV_TOKEN, TK_RSQUARE, 8'h00, 0, ER_NONE), nil);
		add_row(CH_COLON, 0, 1, 1, lex_beat(EV_TOKEN, TK_COLON, 8'h00, 0, ER_NONE), nil);
		add_row(CH_COMMA, 0, 1, 1, lex_beat(EV_TOKEN, TK_COMMA, 8'h00, 0, ER_NONE), nil);
		add_row(CH_SPACE, 0, 1, 0, nil, nil);
		add_row(CH_QUOTE, 0, 1, 0, nil, nil);
		add_row(8'hFF, 0, 1, 1, lex_beat(EV_CONTENT, TK_NONE, 8'hFF, 0, ER_NONE), nil);
		add_row(CH_QUOTE, 0, 1, 1, lex_beat(EV_TOKEN, TK_STRING, 8'h00, 0, ER_NONE), nil);
		add_row(CH_MINUS, 0, 0, 0, nil, nil);
		add_row("9", 0, 0, 0, nil, nil);
		add_row(CH_POINT, 0, 0, 0, nil, nil);
		add_row(CH_NEWLINE, 0, 0, 0, nil, nil);
		add_row(CH_F, 0, 1, 0, nil, nil);
		add_row("a", 0, 0, 0, nil, nil);
		add_row("x", 0, 1, 1, lex_beat(EV_ERROR, TK_NONE, 8'h00, 0, ER_BAD_KEYWORD), nil);
		add_row(CH_LBRACE, 1, 1, 0, nil, nil);
		// lone minus closes as int; a second minus at document end opens a number again
		add_row(CH_MINUS, 0, 0, 0, nil, nil);
		add_row(CH_MINUS, 1, 1, 2, lex_beat(EV_TOKEN, TK_INT, 8'h00, 0, ER_NONE),
			lex_beat(EV_ERROR, TK_NONE, 8'h00, 0, ER_OPEN_NUMBER));
		add_row(CH_ZERO, 0, 0, 0, nil, nil);
		add_row(CH_POINT, 0, 0, 0, nil, nil);
		add_row(CH_POINT, 0, 1, 1, lex_beat(EV_ERROR, TK_NONE, 8'h00, 0, ER_TWO_POINTS), nil);
		add_row(8'h00, 1, 1, 0, nil, nil);
		add_row(CH_QUOTE, 1, 1, 1, lex_beat(EV_ERROR, TK_NONE, 8'h00, 0, ER_OPEN_STRING), nil);
		add_row(8'h01, 0, 1, 1, lex_beat(EV_ERROR, TK_NONE, 8'h00, 0, ER_UNEXPECTED), nil);
		add_row(CH_T, 1, 1, 0, nil, nil);
		add_row(CH_NINE, 1, 1, 2, lex_beat(EV_CONTENT, TK_NONE, CH_NINE, 0, ER_NONE),
			lex_beat(EV_ERROR, TK_NONE, 8'h00, 0, ER_OPEN_NUMBER));
		add_row(CH_T, 0, 0, 0, nil, nil);
		add_row("r", 0, 0, 0, nil, nil);
		add_row("u", 0, 0, 0, nil, nil);
		add_row("e", 1, 1, 1, lex_beat(EV_TOKEN, TK_BOOL, 8'h00, 1, ER_NONE), nil);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].ch, dir_rows[i].eoi);
			predict_byte(dir_rows[i].ch, dir_rows[i].eoi);
			if (dir_rows[i].typed) begin
				typed_q.delete();
				if (dir_rows[i].n >= 1) typed_q.insert(typed_q.size(), dir_rows[i].r0);
				if (dir_rows[i].n >= 2) typed_q.insert(typed_q.size(), dir_rows[i].r1);
				if (typed_q.size() != 0) typed_q[typed_q.size() - 1].last_result = 1'b1;
				foreach (typed_q[j]) lex_expected.insert(lex_expected.size(), typed_q[j]);
			end else begin
				foreach (step_res[j]) lex_expected.insert(lex_expected.size(), step_res[j]);
			end
		end
		wait_quiet();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = SEND_IDLE_PCT[phase];
			recv_stall_pct = RECV_STALL_PCT[phase];
			counted_items  = 0;
			while (counted_items < PHASE_ITEMS) begin
				build_document();
				foreach (doc_bytes[i]) feed_byte(doc_bytes[i], i == doc_bytes.size() - 1);
			end
			wait_quiet();
		end

		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && lex_expected.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/jtl_pkg.sv
hw/rtl/jtl_step.sv
hw/rtl/json_token_lexer_core.sv
dv/testbench.sv
